[rtl/core/pidf_pkg.sv]
// Package: shared types and codes of the PID controller with filtered derivative.
`timescale 1ns / 1ps
package pidf_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned QW      = 32;

    typedef enum logic [CfgIdxW-1:0] {
        REG_GAIN_P     = 3'd0,
        REG_GAIN_I     = 3'd1,
        REG_GAIN_D     = 3'd2,
        REG_LIMIT_LOW  = 3'd3,
        REG_LIMIT_HIGH = 3'd4,
        REG_TARGET     = 3'd5,
        REG_SMOOTHING  = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_P    = 3'd1,
        MUL_I    = 3'd2,
        MUL_T    = 3'd3,
        MUL_FA   = 3'd4,
        MUL_FB   = 3'd5,
        MUL_D    = 3'd6
    } mul_sel_t;

    typedef struct packed {
        logic     in_ready;
        logic     load_in;
        logic     do_err;
        mul_sel_t mul_sel;
        logic     take_prop;
        logic     take_t1;
        logic     do_integ;
        logic     div_start;
        logic     zero_raw;
        logic     take_raw;
        logic     skip_deriv;
        logic     take_acc;
        logic     take_filt;
        logic     take_deriv;
        logic     do_final;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_kind;
        logic first;
        logic dt_zero;
        logic div_done;
        logic out_busy;
    } status_t;

endpackage

[rtl/core/pidf_if.sv]
// Interfaces: sample, result and configuration channels.
`timescale 1ns / 1ps
interface pidf_sample_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] measurement;
    logic [31:0] step_time;
    modport source (output valid, kind, measurement, step_time, input ready);
    modport sink   (input valid, kind, measurement, step_time, output ready);
endinterface

interface pidf_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] drive;
    logic        limited;
    logic        zero_step;
    modport source (output valid, drive, limited, zero_step, input ready);
    modport sink   (input valid, drive, limited, zero_step, output ready);
endinterface

interface pidf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/pidf_div.sv]
// Restoring divider: 48-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module pidf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic        busy_reg, busy_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [47:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] rem_shift;
    logic        fits;

    assign rem_shift = {rem_reg[31:0], q_reg[47]};
    assign fits      = rem_shift >= {1'b0, divisor};
    assign done      = busy_reg && (cnt_reg == 6'd0);
    assign quotient  = q_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 6'd48;
            q_next    = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 6'd0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 6'd1;
                rem_next = fits ? (rem_shift - {1'b0, divisor}) : rem_shift;
                q_next   = {q_reg[46:0], fits};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg || start)
        else $error("divider stayed busy after done");
endmodule

[rtl/core/pidf_dp.sv]
// Datapath: config registers, controller state, shared multiplier and divider.
`timescale 1ns / 1ps
module pidf_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pidf_pkg::cmd_t       cmd,
    output pidf_pkg::status_t    status,
    input  logic                 in_valid,
    input  logic                 in_kind,
    input  logic [31:0]          in_measurement,
    input  logic [31:0]          in_step_time,
    input  logic                 cfg_we,
    input  logic [2:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          out_drive,
    output logic                 out_limited,
    output logic                 out_zero_step
);
    localparam logic signed [66:0] WMax = 67'sd2147483647;
    localparam logic signed [66:0] WMin = -67'sd2147483648;

    function automatic logic [31:0] shr_sat(input logic signed [66:0] p);
        logic signed [66:0] s;
        s = p >>> 16;
        if (s > WMax)
            return 32'h7FFF_FFFF;
        else if (s < WMin)
            return 32'h8000_0000;
        return s[31:0];
    endfunction

    function automatic logic [31:0] sat33(input logic signed [32:0] x);
        if (x[32] != x[31])
            return x[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return x[31:0];
    endfunction

    // upper test first, so with crossed limits a value above the upper one resolves to it, any other to the lower one
    function automatic logic [32:0] clamp34(input logic signed [33:0] x,
                                            input logic signed [31:0] lo,
                                            input logic signed [31:0] hi);
        if (x > 34'(hi))
            return {1'b1, hi};
        else if (x < 34'(lo))
            return {1'b1, lo};
        return {1'b0, x[31:0]};
    endfunction

    logic signed [31:0] gain_p_reg, gain_i_reg, gain_d_reg;
    logic signed [31:0] limit_low_reg, limit_high_reg, target_reg;
    logic [16:0]        smoothing_reg;

    logic               kind_reg;
    logic signed [31:0] meas_reg;
    logic [31:0]        dt_reg;
    logic signed [31:0] err_reg, delta_reg, prop_reg, t1_reg, raw_reg, deriv_reg;
    logic signed [31:0] integral_reg, last_reg, filt_reg;
    logic               first_reg, zstep_reg;
    logic signed [65:0] prod_reg, acc_reg;
    logic               out_valid_reg, limited_reg, zero_step_reg;
    logic [31:0]        drive_reg;

    logic [16:0]        alpha;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_next;
    logic [31:0]        integ_sat;
    logic [32:0]        integ_clamp, final_clamp;
    logic signed [33:0] total;
    logic [31:0]        delta_mag;
    logic               div_done;
    logic [47:0]        quot;
    logic [31:0]        raw_next;

    assign alpha = (smoothing_reg > 17'd65536) ? 17'd65536 : smoothing_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_sel)
            pidf_pkg::MUL_P:
            begin
                mul_a = 33'(gain_p_reg);
                mul_b = 33'(err_reg);
            end
            pidf_pkg::MUL_I:
            begin
                mul_a = 33'(gain_i_reg);
                mul_b = 33'(err_reg);
            end
            pidf_pkg::MUL_T:
            begin
                mul_a = 33'(t1_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            pidf_pkg::MUL_FA:
            begin
                mul_a = $signed({16'b0, alpha});
                mul_b = 33'(raw_reg);
            end
            pidf_pkg::MUL_FB:
            begin
                mul_a = $signed({16'b0, 17'd65536 - alpha});
                mul_b = 33'(filt_reg);
            end
            pidf_pkg::MUL_D:
            begin
                mul_a = 33'(gain_d_reg);
                mul_b = 33'(filt_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next   = 66'(mul_a) * 66'(mul_b);
    assign integ_sat   = sat33(33'(integral_reg) + 33'($signed(shr_sat(67'(prod_reg)))));
    assign integ_clamp = clamp34(34'($signed(integ_sat)), limit_low_reg, limit_high_reg);
    assign total       = 34'(prop_reg) + 34'(integral_reg) - 34'(deriv_reg);
    assign final_clamp = clamp34(total, limit_low_reg, limit_high_reg);
    assign delta_mag   = delta_reg[31] ? (32'd0 - delta_reg) : delta_reg;

    pidf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend ({delta_mag, 16'b0}),
        .divisor  (dt_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // saturate by sign once the magnitude reaches 2^31
    always_comb
    begin
        if (quot >= 48'h0000_8000_0000)
            raw_next = delta_reg[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            raw_next = delta_reg[31] ? (32'd0 - quot[31:0]) : quot[31:0];
    end

    assign status.in_valid = in_valid;
    assign status.in_kind  = in_kind;
    assign status.first    = first_reg;
    assign status.dt_zero  = (dt_reg == 32'd0);
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg     <= '0;
            gain_i_reg     <= '0;
            gain_d_reg     <= '0;
            limit_low_reg  <= 32'sh8000_0000;
            limit_high_reg <= 32'sh7FFF_FFFF;
            target_reg     <= '0;
            smoothing_reg  <= 17'd65536;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pidf_pkg::REG_GAIN_P:     gain_p_reg     <= cfg_data;
                pidf_pkg::REG_GAIN_I:     gain_i_reg     <= cfg_data;
                pidf_pkg::REG_GAIN_D:     gain_d_reg     <= cfg_data;
                pidf_pkg::REG_LIMIT_LOW:  limit_low_reg  <= cfg_data;
                pidf_pkg::REG_LIMIT_HIGH: limit_high_reg <= cfg_data;
                pidf_pkg::REG_TARGET:     target_reg     <= cfg_data;
                pidf_pkg::REG_SMOOTHING:  smoothing_reg  <= cfg_data[16:0];
                default:                  ;
            endcase
        end
    end

    // controller state and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg  <= '0;
            last_reg      <= '0;
            filt_reg      <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in && in_kind)
            begin
                integral_reg <= '0;
                last_reg     <= '0;
                first_reg    <= 1'b1;
            end
            if (cmd.do_integ)
            begin
                integral_reg <= integ_clamp[31:0];
                if (first_reg)
                    first_reg <= 1'b0;
            end
            if (cmd.take_filt)
                filt_reg <= shr_sat(67'(acc_reg) + 67'(prod_reg));
            if (cmd.do_final)
            begin
                out_valid_reg <= 1'b1;
                if (!kind_reg)
                    last_reg <= meas_reg;
            end
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            kind_reg  <= in_kind;
            meas_reg  <= in_measurement;
            dt_reg    <= in_step_time;
            zstep_reg <= 1'b0;
            deriv_reg <= '0;
        end
        if (cmd.do_err)
        begin
            err_reg   <= sat33(33'(target_reg) - 33'(meas_reg));
            delta_reg <= sat33(33'(meas_reg) - 33'(last_reg));
        end
        if (cmd.mul_sel != pidf_pkg::MUL_NONE)
            prod_reg <= prod_next;
        if (cmd.take_prop)
            prop_reg <= shr_sat(67'(prod_reg));
        if (cmd.take_t1)
            t1_reg <= shr_sat(67'(prod_reg));
        if (cmd.zero_raw)
        begin
            raw_reg   <= '0;
            zstep_reg <= 1'b1;
        end
        if (cmd.take_raw)
            raw_reg <= raw_next;
        if (cmd.take_acc)
            acc_reg <= prod_reg;
        if (cmd.skip_deriv)
            deriv_reg <= '0;
        if (cmd.take_deriv)
            deriv_reg <= shr_sat(67'(prod_reg));
        if (cmd.do_final)
        begin
            drive_reg     <= kind_reg ? 32'd0 : final_clamp[31:0];
            limited_reg   <= kind_reg ? 1'b0 : final_clamp[32];
            zero_step_reg <= kind_reg ? 1'b0 : zstep_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_drive     = drive_reg;
    assign out_limited   = limited_reg;
    assign out_zero_step = zero_step_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_in && in_kind) |=> (first_reg && integral_reg == 32'sd0))
        else $error("clear beat did not reset controller state");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && !kind_reg && !limited_reg && (limit_low_reg <= limit_high_reg)
        |-> ($signed(drive_reg) >= limit_low_reg && $signed(drive_reg) <= limit_high_reg))
        else $error("unclamped drive outside limits");
endmodule

[rtl/core/pidf_ctrl.sv]
// Controller: sequences one control step over the shared datapath.
`timescale 1ns / 1ps
module pidf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pidf_pkg::status_t    status,
    output pidf_pkg::cmd_t       cmd
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_ERR   = 14'b00000000000010,
        S_MP    = 14'b00000000000100,
        S_MI    = 14'b00000000001000,
        S_WT1   = 14'b00000000010000,
        S_MT    = 14'b00000000100000,
        S_INTEG = 14'b00000001000000,
        S_DIV   = 14'b00000010000000,
        S_FA    = 14'b00000100000000,
        S_FB    = 14'b00001000000000,
        S_FC    = 14'b00010000000000,
        S_MD    = 14'b00100000000000,
        S_WD    = 14'b01000000000000,
        S_FIN   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = status.in_kind ? S_FIN : S_ERR;
                end
            end
            S_ERR:
            begin
                cmd.do_err = 1'b1;
                state_next = S_MP;
            end
            S_MP:
            begin
                cmd.mul_sel = pidf_pkg::MUL_P;
                state_next  = S_MI;
            end
            S_MI:
            begin
                cmd.take_prop = 1'b1;
                cmd.mul_sel   = pidf_pkg::MUL_I;
                state_next    = S_WT1;
            end
            S_WT1:
            begin
                cmd.take_t1 = 1'b1;
                state_next  = S_MT;
            end
            S_MT:
            begin
                cmd.mul_sel = pidf_pkg::MUL_T;
                state_next  = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.do_integ = 1'b1;
                if (status.first)
                begin
                    cmd.skip_deriv = 1'b1;
                    state_next     = S_FIN;
                end
                else if (status.dt_zero)
                begin
                    cmd.zero_raw = 1'b1;
                    state_next   = S_FA;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.take_raw = 1'b1;
                    state_next   = S_FA;
                end
            end
            S_FA:
            begin
                cmd.mul_sel = pidf_pkg::MUL_FA;
                state_next  = S_FB;
            end
            S_FB:
            begin
                cmd.take_acc = 1'b1;
                cmd.mul_sel  = pidf_pkg::MUL_FB;
                state_next   = S_FC;
            end
            S_FC:
            begin
                cmd.take_filt = 1'b1;
                state_next    = S_MD;
            end
            S_MD:
            begin
                cmd.mul_sel = pidf_pkg::MUL_D;
                state_next  = S_WD;
            end
            S_WD:
            begin
                cmd.take_deriv = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (!status.out_busy)
                begin
                    cmd.do_final = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && status.out_busy) |=> state_reg == S_FIN)
        else $error("final step left while output still held");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && status.in_valid) |=> state_reg != S_IDLE)
        else $error("accepted beat not started");
endmodule

[rtl/core/pid_controller_filtered_derivative.sv]
// Top level: PID controller with filtered derivative and anti-windup.
//
//  channel  dir  payload                              handshake
//  sample   in   kind, measurement, step_time         valid/ready
//  result   out  drive, limited, zero_step            valid/ready
//  cfg      in   index[2:0], data[31:0]               valid/ready (ready tied high)
//
// With the derivative, a control beat runs every sequencer step and the serial divider
// (one quotient bit per cycle). A first sample skips the derivative, a zero step time
// the divider, a clear beat all but the final step. One beat is in work at a time.
// Reset restores the register defaults and the controller state; no sweep.
// A stalled result holds the final step, and with it the sample input.
`timescale 1ns / 1ps
module pid_controller_filtered_derivative (
    input  logic            clk,
    input  logic            rst_n,
    pidf_sample_if.sink     sample,
    pidf_result_if.source   result,
    pidf_cfg_if.sink        cfg
);
    pidf_pkg::cmd_t    cmd;
    pidf_pkg::status_t status;

    assign sample.ready = cmd.in_ready;
    assign cfg.ready    = 1'b1;

    pidf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    pidf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_valid       (sample.valid),
        .in_kind        (sample.kind),
        .in_measurement (sample.measurement),
        .in_step_time   (sample.step_time),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .out_drive      (result.drive),
        .out_limited    (result.limited),
        .out_zero_step  (result.zero_step)
    );
endmodule
